// ===== sv/dcci_pkg.sv =====
// Shared types, opcodes and cursor helpers for the display controller command interface.
package dcci_pkg;

   localparam int PANEL_WIDTH  = 160;
   localparam int PANEL_HEIGHT = 128;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] OP_NONE    = 8'h00;
   localparam logic [7:0] OP_SWRESET = 8'h01;
   localparam logic [7:0] OP_INVOFF  = 8'h20;
   localparam logic [7:0] OP_INVON   = 8'h21;
   localparam logic [7:0] OP_DISPOFF = 8'h28;
   localparam logic [7:0] OP_DISPON  = 8'h29;
   localparam logic [7:0] OP_CASET   = 8'h2A;
   localparam logic [7:0] OP_RASET   = 8'h2B;
   localparam logic [7:0] OP_RAMWR   = 8'h2C;
   localparam logic [7:0] OP_COLMOD  = 8'h3A;

   localparam logic [1:0] FMT_12 = 2'd0;
   localparam logic [1:0] FMT_16 = 2'd1;
   localparam logic [1:0] FMT_18 = 2'd2;

   localparam logic [7:0] COLMOD_12 = 8'd3;
   localparam logic [7:0] COLMOD_16 = 8'd5;
   localparam logic [7:0] COLMOD_18 = 8'd6;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] row;
   } cursor_type;

   typedef struct packed {
      cursor_type pos;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   typedef struct packed {
      logic [1:0]      count;
      pix_type [1:0]   px;
      logic            inv;
      logic            disp;
      logic [1:0]      fmt;
   } job_type;

   function automatic logic on_panel(cursor_type c);
      on_panel = ({1'b0, c.col} < 9'(PANEL_WIDTH)) && ({1'b0, c.row} < 9'(PANEL_HEIGHT));
   endfunction

   function automatic cursor_type advance(cursor_type c, logic [7:0] cs, logic [7:0] ce,
                                          logic [7:0] rs, logic [7:0] re);
      cursor_type n;
      n = c;
      if (c.col >= ce) begin
         n.col = cs;
         if (c.row >= re) begin
            n.row = rs;
         end else begin
            n.row = c.row + 8'd1;
         end
      end else begin
         n.col = c.col + 8'd1;
      end
      return n;
   endfunction

endpackage

// ===== sv/dcci_front.sv =====
// Front end: accepts link bytes, decodes commands, assembles pixels and walks the cursor.
module dcci_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 cmd,
   input  logic [7:0]           byte_value,
   output dcci_pkg::job_type    job
);

   logic [7:0]       opcode_ff, opcode_in;
   logic [3:0][7:0]  params_ff, params_in;
   logic [2:0]       ptotal_ff, ptotal_in;
   logic [2:0][7:0]  pbytes_ff, pbytes_in;
   logic [1:0]       pcnt_ff, pcnt_in;
   logic [1:0]       fmt_ff, fmt_in;
   logic             inv_ff, inv_in;
   logic             disp_ff, disp_in;
   logic [7:0]       cs_ff, cs_in, ce_ff, ce_in, rs_ff, rs_in, re_ff, re_in;
   dcci_pkg::cursor_type cur_ff, cur_in;

   dcci_pkg::cursor_type cur;
   dcci_pkg::pix_type    p0, p1;
   logic [1:0]           idx;
   logic [2:0]           newcnt;
   logic [1:0]           nput;
   logic                 slot;
   logic [1:0]           emitted;

   always_comb begin
      opcode_in = opcode_ff;
      params_in = params_ff;
      ptotal_in = ptotal_ff;
      pbytes_in = pbytes_ff;
      pcnt_in   = pcnt_ff;
      fmt_in    = fmt_ff;
      inv_in    = inv_ff;
      disp_in   = disp_ff;
      cs_in     = cs_ff;
      ce_in     = ce_ff;
      rs_in     = rs_ff;
      re_in     = re_ff;
      cur       = cur_ff;
      p0        = '0;
      p1        = '0;
      idx       = 2'd0;
      newcnt    = 3'd0;
      nput      = 2'd0;
      slot      = 1'b0;
      emitted   = 2'd0;
      job       = '0;
      if (!cmd) begin
         ptotal_in = 3'd0;
         pcnt_in   = 2'd0;
         opcode_in = dcci_pkg::OP_NONE;
         unique case (byte_value)
            dcci_pkg::OP_INVOFF:  inv_in  = 1'b0;
            dcci_pkg::OP_INVON:   inv_in  = 1'b1;
            dcci_pkg::OP_DISPOFF: disp_in = 1'b0;
            dcci_pkg::OP_DISPON:  disp_in = 1'b1;
            dcci_pkg::OP_SWRESET: begin
               fmt_in  = dcci_pkg::FMT_18;
               inv_in  = 1'b0;
               disp_in = 1'b0;
               cur     = '0;
            end
            default: opcode_in = byte_value;
         endcase
      end else if (opcode_ff == dcci_pkg::OP_RAMWR) begin
         idx = (pcnt_ff > 2'd2) ? 2'd0 : pcnt_ff;
         pbytes_in[idx] = byte_value;
         newcnt = {1'b0, idx} + 3'd1;
         pcnt_in = newcnt[1:0];
         if (fmt_ff == dcci_pkg::FMT_16) begin
            if (newcnt >= 3'd2) begin
               nput = 2'd1;
               p0.red   = pbytes_in[0] & 8'hF8;
               p0.green = {pbytes_in[0][2:0], 5'd0} | ({3'd0, pbytes_in[1][7:3]} & 8'h1C);
               p0.blue  = {pbytes_in[1][4:0], 3'd0};
               pcnt_in  = 2'd0;
            end
         end else if (newcnt >= 3'd3) begin
            pcnt_in = 2'd0;
            if (fmt_ff == dcci_pkg::FMT_12) begin
               nput = 2'd2;
               p0.red   = pbytes_in[0] & 8'hF0;
               p0.green = {pbytes_in[0][3:0], 4'd0};
               p0.blue  = pbytes_in[1] & 8'hF0;
               p1.red   = {pbytes_in[1][3:0], 4'd0};
               p1.green = pbytes_in[2] & 8'hF0;
               p1.blue  = {pbytes_in[2][3:0], 4'd0};
            end else begin
               nput = 2'd1;
               p0.red   = pbytes_in[0] & 8'hFC;
               p0.green = pbytes_in[1] & 8'hFC;
               p0.blue  = pbytes_in[2] & 8'hFC;
            end
         end
         if (nput != 2'd0) begin
            if (dcci_pkg::on_panel(cur)) begin
               p0.pos = cur;
               job.px[0] = p0;
               slot = 1'b1;
               emitted = 2'd1;
            end
            cur = dcci_pkg::advance(cur, cs_ff, ce_ff, rs_ff, re_ff);
         end
         if (nput == 2'd2) begin
            if (dcci_pkg::on_panel(cur)) begin
               p1.pos = cur;
               job.px[slot] = p1;
               emitted = emitted + 2'd1;
            end
            cur = dcci_pkg::advance(cur, cs_ff, ce_ff, rs_ff, re_ff);
         end
      end else begin
         if (ptotal_ff < 3'd4) begin
            params_in[ptotal_ff[1:0]] = byte_value;
            ptotal_in = ptotal_ff + 3'd1;
         end
         if (opcode_ff == dcci_pkg::OP_CASET && ptotal_in == 3'd4) begin
            cs_in     = params_in[1];
            ce_in     = params_in[3];
            cur.col   = params_in[1];
            opcode_in = dcci_pkg::OP_NONE;
            ptotal_in = 3'd0;
         end else if (opcode_ff == dcci_pkg::OP_RASET && ptotal_in == 3'd4) begin
            rs_in     = params_in[1];
            re_in     = params_in[3];
            cur.row   = params_in[1];
            opcode_in = dcci_pkg::OP_NONE;
            ptotal_in = 3'd0;
         end else if (opcode_ff == dcci_pkg::OP_COLMOD && ptotal_in == 3'd1) begin
            unique case (params_in[0])
               dcci_pkg::COLMOD_12: fmt_in = dcci_pkg::FMT_12;
               dcci_pkg::COLMOD_16: fmt_in = dcci_pkg::FMT_16;
               dcci_pkg::COLMOD_18: fmt_in = dcci_pkg::FMT_18;
               default:             fmt_in = fmt_ff;
            endcase
            opcode_in = dcci_pkg::OP_NONE;
            ptotal_in = 3'd0;
         end
      end
      cur_in    = cur;
      job.count = emitted;
      job.inv   = inv_in;
      job.disp  = disp_in;
      job.fmt   = fmt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff <= dcci_pkg::OP_NONE;
         ptotal_ff <= 3'd0;
         pcnt_ff   <= 2'd0;
         fmt_ff    <= dcci_pkg::FMT_18;
         inv_ff    <= 1'b0;
         disp_ff   <= 1'b0;
         cs_ff     <= 8'd0;
         ce_ff     <= 8'(dcci_pkg::PANEL_WIDTH - 1);
         rs_ff     <= 8'd0;
         re_ff     <= 8'(dcci_pkg::PANEL_HEIGHT - 1);
         cur_ff    <= '0;
      end else if (accept) begin
         opcode_ff <= opcode_in;
         ptotal_ff <= ptotal_in;
         pcnt_ff   <= pcnt_in;
         fmt_ff    <= fmt_in;
         inv_ff    <= inv_in;
         disp_ff   <= disp_in;
         cs_ff     <= cs_in;
         ce_ff     <= ce_in;
         rs_ff     <= rs_in;
         re_ff     <= re_in;
         cur_ff    <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         params_ff <= params_in;
         pbytes_ff <= pbytes_in;
      end
   end

endmodule

// ===== sv/dcci_queue.sv =====
// Short job queue between the decode front end and the result back end.
module dcci_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dcci_pkg::job_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              nonempty,
   output dcci_pkg::job_type head
);

   dcci_pkg::job_type entries [dcci_pkg::QUEUE_DEPTH];

   logic [dcci_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dcci_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == dcci_pkg::QCNT_W'(dcci_pkg::QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/dcci_back.sv =====
// Back end: expands queued jobs into results and holds them in the output register.
module dcci_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              nonempty,
   input  dcci_pkg::job_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_pixel_valid,
   output logic [14:0]       rsp_pixel_addr,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic              rsp_last,
   output logic              rsp_inverted_now,
   output logic              rsp_display_enabled,
   output logic [1:0]        rsp_format_now
);

   logic              sub_ff, sub_in;
   logic              valid_ff, valid_in;
   logic              pvalid_ff;
   logic [14:0]       addr_ff;
   logic [7:0]        red_ff, green_ff, blue_ff;
   logic              last_ff, inv_ff, disp_ff;
   logic [1:0]        fmt_ff;

   logic              load;
   logic              last_sel;
   logic              has_pix;
   dcci_pkg::pix_type sel;
   logic [15:0]       addr_full;

   assign load     = nonempty && (!valid_ff || rsp_ready);
   assign last_sel = (head.count < 2'd2) || sub_ff;
   assign pop      = load && last_sel;
   assign has_pix  = (head.count != 2'd0);
   assign sel      = has_pix ? head.px[sub_ff] : '0;
   assign addr_full = 16'(sel.pos.row) * 16'(dcci_pkg::PANEL_WIDTH) + 16'(sel.pos.col);

   always_comb begin
      sub_in   = load ? !last_sel : sub_ff;
      valid_in = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pvalid_ff <= has_pix;
         addr_ff   <= addr_full[14:0];
         red_ff    <= sel.red;
         green_ff  <= sel.green;
         blue_ff   <= sel.blue;
         last_ff   <= last_sel;
         inv_ff    <= head.inv;
         disp_ff   <= head.disp;
         fmt_ff    <= head.fmt;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_pixel_valid     = pvalid_ff;
   assign rsp_pixel_addr      = addr_ff;
   assign rsp_red             = red_ff;
   assign rsp_green           = green_ff;
   assign rsp_blue            = blue_ff;
   assign rsp_last            = last_ff;
   assign rsp_inverted_now    = inv_ff;
   assign rsp_display_enabled = disp_ff;
   assign rsp_format_now      = fmt_ff;

endmodule

// ===== sv/display_controller_command_interface.sv =====
// Top level of the display controller command interface.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_cmd, req_byte_value
//   rsp      out        rsp_valid / rsp_ready  pixel_valid, pixel_addr, red, green, blue,
//                                              last, inverted_now, display_enabled, format_now
//
// One request is accepted per cycle while the four-entry job queue has room.
// A request makes one or two responses; a 12-bit byte triple packs two pixels, one per response.
// A request's job is registered in the queue, then its response in the output register.
// Reset is synchronous; it empties the queue and clears the output valid and controller state.
// A stalled response backs up into the queue; req_ready drops only when it is full.
module display_controller_command_interface (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pixel_valid,
   output logic [14:0] rsp_pixel_addr,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,
   output logic        rsp_inverted_now,
   output logic        rsp_display_enabled,
   output logic [1:0]  rsp_format_now
);

   logic              accept;
   logic              q_full;
   logic              q_nonempty;
   logic              q_pop;
   dcci_pkg::job_type job;
   dcci_pkg::job_type head;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   dcci_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_cmd),
      .byte_value (req_byte_value),
      .job        (job)
   );

   dcci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (job),
      .pop       (q_pop),
      .full      (q_full),
      .nonempty  (q_nonempty),
      .head      (head)
   );

   dcci_back u_back (
      .clock               (clock),
      .reset               (reset),
      .nonempty            (q_nonempty),
      .head                (head),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_valid     (rsp_pixel_valid),
      .rsp_pixel_addr      (rsp_pixel_addr),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .rsp_last            (rsp_last),
      .rsp_inverted_now    (rsp_inverted_now),
      .rsp_display_enabled (rsp_display_enabled),
      .rsp_format_now      (rsp_format_now)
   );

endmodule
